[hdl/lmf_pkg.sv]
// Shared types and constants for the 3x3 local maxima finder.
package lmf_pkg;

   localparam int DEF_MAX_COLS   = 1024;
   localparam int DEF_MAX_ROWS   = 1024;
   localparam int DEF_PIXEL_BITS = 16;

   localparam int SIZE_BITS     = 11;
   localparam int COUNT_BITS    = 16;
   localparam int VALUE_BITS    = 16;
   localparam int COORD_BITS    = 10;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_COLS = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_ROWS = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_COUNT  = 2'd2;

   typedef enum logic [1:0] {
      KIND_PEAK     = 2'd0,
      KIND_DONE     = 2'd1,
      KIND_OVERFLOW = 2'd2
   } lmf_kind_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0]  image_cols;
      logic [SIZE_BITS-1:0]  image_rows;
      logic [COUNT_BITS-1:0] max_count;
   } lmf_cfg_type;

   typedef struct packed {
      lmf_kind_type          kind;
      logic [VALUE_BITS-1:0] peak_value;
      logic [COORD_BITS-1:0] peak_x;
      logic [COORD_BITS-1:0] peak_y;
      logic [COUNT_BITS-1:0] found_count;
      logic                  last_of_frame;
   } lmf_result_type;

   typedef struct packed {
      logic           two;
      lmf_result_type first;
      lmf_result_type second;
   } lmf_group_type;

endpackage

[hdl/lmf_ram.sv]
// Generic simple dual-port RAM with registered read.
module lmf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/lmf_front.sv]
// Front end: raster counters, line stores, 3x3 window and peak classification.
module lmf_front #(
   parameter int MAX_COLS   = lmf_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS   = lmf_pkg::DEF_MAX_ROWS,
   parameter int PIXEL_BITS = lmf_pkg::DEF_PIXEL_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lmf_pkg::lmf_cfg_type  cfg,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIXEL_BITS-1:0] req_pixel,
   output logic                  grp_push,
   output lmf_pkg::lmf_group_type grp_data,
   input  logic                  q_full
);
   import lmf_pkg::*;

   localparam int CW = $clog2(MAX_COLS);
   localparam int RW = $clog2(MAX_ROWS);
   localparam int PW = PIXEL_BITS;

   logic [CW-1:0]         col_ff, col_in;
   logic [RW-1:0]         row_ff, row_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic [PW-1:0]         s1_pix_ff;
   logic [CW-1:0]         s1_col_ff;
   logic [RW-1:0]         s1_row_ff;
   logic                  s1_test_ff;
   logic                  s1_frame_end_ff;
   logic [PW-1:0]         win_ff [3][3];
   logic [PW-1:0]         win_in [3][3];
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic                  ovf_ff, ovf_in;

   logic [CW:0]           cols_c;
   logic [RW:0]           rows_c;
   logic                  accept, s1_adv, row_end, frame_end;
   logic [2*PW-1:0]       rd_data;
   logic [PW-1:0]         up_v, mid_v, v;
   logic                  is_max, peak_hit, ovf_hit, done_hit;
   lmf_result_type        peak_res, done_res;

   always_comb begin
      if (cfg.image_cols < SIZE_BITS'(3)) begin
         cols_c = (CW+1)'(3);
      end else if (32'(cfg.image_cols) > MAX_COLS) begin
         cols_c = (CW+1)'(MAX_COLS);
      end else begin
         cols_c = (CW+1)'(cfg.image_cols);
      end
      if (cfg.image_rows < SIZE_BITS'(3)) begin
         rows_c = (RW+1)'(3);
      end else if (32'(cfg.image_rows) > MAX_ROWS) begin
         rows_c = (RW+1)'(MAX_ROWS);
      end else begin
         rows_c = (RW+1)'(cfg.image_rows);
      end
   end

   assign s1_adv     = s1_valid_ff && !q_full;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;

   assign row_end   = ({1'b0, col_ff} + (CW+1)'(1)) >= cols_c;
   assign frame_end = row_end && (({1'b0, row_ff} + (RW+1)'(1)) >= rows_c);

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      s1_valid_in = s1_valid_ff;
      if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         if (frame_end) begin
            col_in = '0;
            row_in = '0;
         end else if (row_end) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   lmf_ram #(
      .WIDTH(2*PW),
      .DEPTH(MAX_COLS)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (s1_adv),
      .wr_addr(s1_col_ff),
      .wr_data({mid_v, s1_pix_ff}),
      .rd_en  (accept),
      .rd_addr(col_ff),
      .rd_data(rd_data)
   );

   assign up_v  = rd_data[2*PW-1:PW];
   assign mid_v = rd_data[PW-1:0];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_in[i][0] = win_ff[i][1];
         win_in[i][1] = win_ff[i][2];
      end
      win_in[0][2] = up_v;
      win_in[1][2] = mid_v;
      win_in[2][2] = s1_pix_ff;
   end

   assign v = win_in[1][1];
   assign is_max = v > win_in[0][0] && v > win_in[0][1] && v > win_in[0][2] &&
                   v > win_in[1][0] && v >= win_in[1][2] &&
                   v >= win_in[2][0] && v >= win_in[2][1] && v >= win_in[2][2];

   assign peak_hit = s1_test_ff && !ovf_ff && is_max;
   assign ovf_hit  = peak_hit && (cnt_ff >= cfg.max_count);

   always_comb begin
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (peak_hit) begin
         if (ovf_hit) begin
            ovf_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + COUNT_BITS'(1);
         end
      end
   end

   assign done_hit = s1_frame_end_ff && !ovf_in;

   always_comb begin
      peak_res = '0;
      if (ovf_hit) begin
         peak_res.kind          = KIND_OVERFLOW;
         peak_res.found_count   = cfg.max_count;
         peak_res.last_of_frame = 1'b1;
      end else begin
         peak_res.kind        = KIND_PEAK;
         peak_res.peak_value  = VALUE_BITS'(v);
         peak_res.peak_x      = COORD_BITS'(s1_col_ff - CW'(1));
         peak_res.peak_y      = COORD_BITS'(s1_row_ff - RW'(1));
         peak_res.found_count = cnt_in;
      end
      done_res               = '0;
      done_res.kind          = KIND_DONE;
      done_res.found_count   = cnt_in;
      done_res.last_of_frame = 1'b1;
   end

   always_comb begin
      grp_data = '0;
      if (peak_hit) begin
         grp_data.first  = peak_res;
         grp_data.second = done_res;
         grp_data.two    = done_hit;
      end else begin
         grp_data.first = done_res;
      end
   end

   assign grp_push = s1_adv && (peak_hit || done_hit);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         cnt_ff      <= '0;
         ovf_ff      <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         if (s1_adv) begin
            win_ff <= win_in;
            if (s1_frame_end_ff) begin
               cnt_ff <= '0;
               ovf_ff <= 1'b0;
            end else begin
               cnt_ff <= cnt_in;
               ovf_ff <= ovf_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff       <= req_pixel;
         s1_col_ff       <= col_ff;
         s1_row_ff       <= row_ff;
         s1_test_ff      <= (col_ff >= CW'(2)) && (row_ff >= RW'(2));
         s1_frame_end_ff <= frame_end;
      end
   end

endmodule

[hdl/lmf_queue.sv]
// Short queue of result groups between front end and back end.
module lmf_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lmf_pkg::lmf_group_type push_data,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output lmf_pkg::lmf_group_type head_data
);
   import lmf_pkg::*;

   localparam int DEPTH = QUEUE_DEPTH;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW    = $clog2(DEPTH + 1);

   lmf_group_type  entry_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]  fill_ff, fill_in;
   logic           do_push, do_pop;

   assign full       = fill_ff == NW'(DEPTH);
   assign head_valid = fill_ff != '0;
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/lmf_back.sv]
// Back end: unpacks result groups into single items behind an output register.
module lmf_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  lmf_pkg::lmf_group_type head_data,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output lmf_pkg::lmf_result_type rsp_result
);
   import lmf_pkg::*;

   logic           out_valid_ff, out_valid_in;
   lmf_result_type out_ff, out_in;
   logic           second_valid_ff, second_valid_in;
   lmf_result_type second_ff, second_in;
   logic           load;

   assign load = !out_valid_ff || rsp_tready;
   assign pop  = load && !second_valid_ff && head_valid;

   always_comb begin
      out_valid_in    = out_valid_ff;
      out_in          = out_ff;
      second_valid_in = second_valid_ff;
      second_in       = second_ff;
      if (load) begin
         if (second_valid_ff) begin
            out_in          = second_ff;
            out_valid_in    = 1'b1;
            second_valid_in = 1'b0;
         end else if (head_valid) begin
            out_in          = head_data.first;
            out_valid_in    = 1'b1;
            second_in       = head_data.second;
            second_valid_in = head_data.two;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff    <= 1'b0;
         second_valid_ff <= 1'b0;
      end else begin
         out_valid_ff    <= out_valid_in;
         second_valid_ff <= second_valid_in;
      end
      out_ff    <= out_in;
      second_ff <= second_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_result = out_ff;

endmodule

[hdl/local_maxima_3x3_finder_core.sv]
// Top level of the 3x3 local maxima finder.
//
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  tdata: pixel
//  rsp      out        rsp_tvalid/rsp_tready  tdata: value,x,y,count; tuser: kind; tlast
//  csr      in         csr_wr_en              csr_index, csr_wr_data
//
// One pixel per clock while the group queue is not full; in the front end a
// pixel and its line store read are registered, then the window shifts and is tested.
// A pixel that yields a peak and the frame done gives two output items.
// Reset is synchronous; the line store needs no clearing pass.
// Output stalls back up through a two-entry group queue into req_tready.
module local_maxima_3x3_finder_core #(
   parameter int MAX_COLS   = lmf_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS   = lmf_pkg::DEF_MAX_ROWS,
   parameter int PIXEL_BITS = lmf_pkg::DEF_PIXEL_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,   // pixel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [55:0]                         rsp_tdata,   // peak_value, peak_x, peak_y, found_count
   output logic [1:0]                          rsp_tuser,   // kind
   output logic                                rsp_tlast,   // last_of_frame
   input  logic                                csr_wr_en,
   input  logic [lmf_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [lmf_pkg::CSR_DATA_BITS-1:0]   csr_wr_data
);
   import lmf_pkg::*;

   lmf_cfg_type    cfg_ff;
   lmf_group_type  grp_data, head_data;
   lmf_result_type rsp_result;
   logic           grp_push, q_full, head_valid, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_cols <= SIZE_BITS'(1024);
         cfg_ff.image_rows <= SIZE_BITS'(1024);
         cfg_ff.max_count  <= COUNT_BITS'(65535);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_COLS: begin
               cfg_ff.image_cols <= csr_wr_data[SIZE_BITS-1:0];
            end
            CSR_IMAGE_ROWS: begin
               cfg_ff.image_rows <= csr_wr_data[SIZE_BITS-1:0];
            end
            CSR_MAX_COUNT: begin
               cfg_ff.max_count <= csr_wr_data[COUNT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   lmf_front #(
      .MAX_COLS  (MAX_COLS),
      .MAX_ROWS  (MAX_ROWS),
      .PIXEL_BITS(PIXEL_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_pixel (PIXEL_BITS'(req_tdata)),
      .grp_push  (grp_push),
      .grp_data  (grp_data),
      .q_full    (q_full)
   );

   lmf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (grp_push),
      .push_data (grp_data),
      .full      (q_full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_data (head_data)
   );

   lmf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head_data (head_data),
      .pop       (pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_result(rsp_result)
   );

   assign rsp_tdata = {4'b0, rsp_result.found_count, rsp_result.peak_y,
                       rsp_result.peak_x, rsp_result.peak_value};
   assign rsp_tuser = rsp_result.kind;
   assign rsp_tlast = rsp_result.last_of_frame;

   assert property (@(posedge clock) disable iff (reset) !(grp_push && q_full))
      else $error("result group pushed into full queue");

   assert property (@(posedge clock) disable iff (reset) head_valid |=> rsp_tvalid)
      else $error("queued results not moved to output");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_PEAK |-> !rsp_tlast)
      else $error("peak item marked last of frame");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_DONE || rsp_tuser == KIND_OVERFLOW)
      |-> rsp_tlast && rsp_tdata[15:0] == 16'd0)
      else $error("frame end item malformed");

endmodule
